// ----- sv/icmp_chk_pkg.sv -----
// Shared types, codes and helper functions of the ICMP message checker.
`default_nettype none

package icmp_chk_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNSUP   = 2'd1,
      ST_BAD_SUM = 2'd2,
      ST_SHORT   = 2'd3
   } status_type;

   // ICMP type codes that the checker accepts
   localparam logic [7:0] ICMP_ECHO_REPLY     = 8'd0;
   localparam logic [7:0] ICMP_DEST_UNREACH   = 8'd3;
   localparam logic [7:0] ICMP_QUENCH         = 8'd4;
   localparam logic [7:0] ICMP_REROUTE        = 8'd5;
   localparam logic [7:0] ICMP_ECHO_REQUEST   = 8'd8;
   localparam logic [7:0] ICMP_TTL_EXPIRED    = 8'd11;
   localparam logic [7:0] ICMP_PARAM_PROBLEM  = 8'd12;
   localparam logic [7:0] ICMP_TSTAMP_REQ     = 8'd13;
   localparam logic [7:0] ICMP_TSTAMP_REPLY   = 8'd14;
   localparam logic [7:0] ICMP_INFO_REQUEST   = 8'd15;
   localparam logic [7:0] ICMP_INFO_REPLY     = 8'd16;

   // Byte positions within the header
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] POS_TYPE    = 4'd0;
   localparam logic [POS_W-1:0] POS_CODE    = 4'd1;
   localparam logic [POS_W-1:0] POS_CSUM_HI = 4'd2;
   localparam logic [POS_W-1:0] POS_CSUM_LO = 4'd3;
   localparam logic [POS_W-1:0] POS_ID_HI   = 4'd4;
   localparam logic [POS_W-1:0] POS_ID_LO   = 4'd5;
   localparam logic [POS_W-1:0] POS_SEQ_HI  = 4'd6;
   localparam logic [POS_W-1:0] POS_SEQ_LO  = 4'd7;
   localparam logic [POS_W-1:0] POS_SAT     = 4'd8;

   localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

   // One result item
   typedef struct packed {
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] stored_checksum;
      logic [15:0] echo_ident;
      logic [15:0] echo_seq;
      status_type  status;
   } result_type;

   // Ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic type_supported(input logic [7:0] t);
      logic ok;
      case (t) inside
         ICMP_ECHO_REPLY, ICMP_DEST_UNREACH, ICMP_QUENCH, ICMP_REROUTE,
         ICMP_ECHO_REQUEST, ICMP_TTL_EXPIRED, ICMP_PARAM_PROBLEM,
         ICMP_TSTAMP_REQ, ICMP_TSTAMP_REPLY, ICMP_INFO_REQUEST,
         ICMP_INFO_REPLY: ok = 1'b1;
         default:         ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// ----- sv/icmp_chk_if.sv -----
// Valid/ready channel interfaces for message bytes and check results.
`default_nettype none

interface icmp_chk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icmp_chk_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  msg_type;
   logic [7:0]  msg_code;
   logic [15:0] stored_checksum;
   logic [15:0] echo_ident;
   logic [15:0] echo_seq;
   logic [1:0]  status;

   modport source (output valid, output msg_type, output msg_code,
                   output stored_checksum, output echo_ident, output echo_seq,
                   output status, input ready);
   modport sink   (input valid, input msg_type, input msg_code,
                   input stored_checksum, input echo_ident, input echo_seq,
                   input status, output ready);
endinterface

`default_nettype wire

// ----- sv/icmp_chk_parse.sv -----
// Per-byte header capture and running ones' complement sum of one message.
`default_nettype none

module icmp_chk_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   output      logic               done,
   output      icmp_chk_pkg::result_type result
);
   import icmp_chk_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             pending_ff, pending_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      csum_ff, csum_in;
   logic [15:0]      ident_ff, ident_in;
   logic [15:0]      seq_ff, seq_in;
   logic [15:0]      word;
   logic [15:0]      sum_add;
   logic             is_echo;

   // Capture header fields by byte position
   always_comb begin
      type_in  = type_ff;
      code_in  = code_ff;
      csum_in  = csum_ff;
      ident_in = ident_ff;
      seq_in   = seq_ff;
      unique case (pos_ff)
         POS_TYPE:    type_in  = data_byte;
         POS_CODE:    code_in  = data_byte;
         POS_CSUM_HI: csum_in  = {data_byte, 8'd0};
         POS_CSUM_LO: csum_in  = {csum_ff[15:8], data_byte};
         POS_ID_HI:   ident_in = {data_byte, 8'd0};
         POS_ID_LO:   ident_in = {ident_ff[15:8], data_byte};
         POS_SEQ_HI:  seq_in   = {data_byte, 8'd0};
         POS_SEQ_LO:  seq_in   = {seq_ff[15:8], data_byte};
         default: ;
      endcase
   end

   // Form the next word: a completed pair, or the last byte padded with zero
   assign word    = pending_ff ? {held_ff, data_byte} : {data_byte, 8'd0};
   assign sum_add = oc_add(sum_ff, word);

   // Advance position, pairing and sum
   always_comb begin
      pos_in     = (pos_ff < POS_SAT) ? pos_ff + 1'b1 : pos_ff;
      pending_in = ~pending_ff;
      held_in    = pending_ff ? 8'd0 : data_byte;
      sum_in     = (pending_ff || last_byte) ? sum_add : sum_ff;
   end

   // Build the result of a closing byte
   assign is_echo = (type_in == ICMP_ECHO_REPLY) || (type_in == ICMP_ECHO_REQUEST);
   assign done    = take & last_byte;

   always_comb begin
      result.msg_type        = type_in;
      result.msg_code        = code_in;
      result.stored_checksum = csum_in;
      result.echo_ident      = 16'd0;
      result.echo_seq        = 16'd0;
      if (pos_ff < POS_CSUM_LO) begin
         result.status = ST_SHORT;
      end else if (!type_supported(type_in)) begin
         result.status = ST_UNSUP;
      end else begin
         if (is_echo) begin
            result.echo_ident = ident_in;
            result.echo_seq   = seq_in;
         end
         result.status = (sum_add == SUM_ALL_ONES) ? ST_OK : ST_BAD_SUM;
      end
   end

   // Hold state; clear it at reset and after each closing byte
   always_ff @(posedge clock) begin
      if (reset || done) begin
         pos_ff     <= POS_TYPE;
         pending_ff <= 1'b0;
         held_ff    <= 8'd0;
         sum_ff     <= 16'd0;
         type_ff    <= 8'd0;
         code_ff    <= 8'd0;
         csum_ff    <= 16'd0;
         ident_ff   <= 16'd0;
         seq_ff     <= 16'd0;
      end else if (take) begin
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
         sum_ff     <= sum_in;
         type_ff    <= type_in;
         code_ff    <= code_in;
         csum_ff    <= csum_in;
         ident_ff   <= ident_in;
         seq_ff     <= seq_in;
      end
   end

   // Position never passes saturation, and pairing follows its low bit
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_SAT)
      else $error("byte position beyond saturation");
   assert property (@(posedge clock) disable iff (reset)
                    (pos_ff < POS_SAT) |-> (pending_ff == pos_ff[0]))
      else $error("odd byte flag out of step with byte position");
   assert property (@(posedge clock) disable iff (reset)
                    done |=> (pos_ff == POS_TYPE && !pending_ff && sum_ff == 16'd0))
      else $error("state not cleared after closing byte");

endmodule

`default_nettype wire

// ----- sv/icmp_message_checker_core.sv -----
// Top level of the ICMP message checker: byte intake, parser and result buffer.
//
// Usage:
//   req_chan carries one message byte per item (data_byte, last_byte); the first
//   byte of a message is the ICMP type. rsp_chan carries one result item per
//   message, made when the item with last_byte set is taken.
//   Throughput is one byte per cycle while req_chan.ready is high; each byte
//   pair, or a padded last byte, is folded into the ones' complement sum in
//   the cycle its final byte is taken, by one 16-bit add with end-around carry.
//   Each result is registered in the result register, or in the skid entry if that register is full and not taken.
//   The result register is backed by one skid entry, so bytes keep flowing
//   while a result waits. If the receiver stalls and a second result lands in
//   the skid entry, req_chan.ready drops until the result register drains.
//   Status: 0 ok, 1 unsupported type, 2 checksum bad, 3 too short.
//   Reset (synchronous, active high) clears the message state and drops both
//   buffered results; req_chan.ready is high the cycle after reset.
`default_nettype none

module icmp_message_checker_core (
   input  wire logic   clock,
   input  wire logic   reset,
   icmp_chk_req_if.sink   req_chan,
   icmp_chk_rsp_if.source rsp_chan
);
   import icmp_chk_pkg::*;

   logic       take;
   logic       done;
   result_type new_result;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       pop;

   assign req_chan.ready = ~skid_valid_ff;
   assign take           = req_chan.valid & req_chan.ready;
   assign pop            = out_valid_ff & rsp_chan.ready;

   icmp_chk_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .done      (done),
      .result    (new_result)
   );

   // Advance the result register and the skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (done) begin
            out_ff       <= new_result;
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (done) begin
         skid_ff       <= new_result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.msg_type        = out_ff.msg_type;
   assign rsp_chan.msg_code        = out_ff.msg_code;
   assign rsp_chan.stored_checksum = out_ff.stored_checksum;
   assign rsp_chan.echo_ident      = out_ff.echo_ident;
   assign rsp_chan.echo_seq        = out_ff.echo_seq;
   assign rsp_chan.status          = out_ff.status;

   // Skid entry is only used behind a full result register
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while result register is empty");
   assert property (@(posedge clock) disable iff (reset)
                    (done && out_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("result dropped while receiver stalls");
   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result changed while receiver stalls");

endmodule

`default_nettype wire
